### sv/qrs_pkg.sv
package qrs_pkg;

    typedef enum logic [1:0] {
        CNT_NONE = 2'd0,
        CNT_ONE  = 2'd1,
        CNT_TWO  = 2'd2,
        CNT_INF  = 2'd3
    } cnt_t;

    localparam int COEF_W    = 16;
    localparam int PROD_W    = 32;
    localparam int DISC_W    = 34;
    localparam int RAD_W     = 64;
    localparam int SQ_STEPS  = 32;
    localparam int SQ_REM_W  = 34;
    localparam int NUM_W     = 42;
    localparam int QUO_W     = 43;
    localparam int ROOT_W    = 48;
    localparam int RAD_SHIFT = 30;
    localparam int QUAD_SH   = 15;
    localparam int DZERO_SH  = 23;
    localparam int LIN_SH    = 24;
    localparam int NUM_SH    = 8;

    localparam logic signed [QUO_W-1:0] FLUSH_LIM = 43'sd167;

    typedef struct packed {
        cnt_t                      cnt;
        logic                      use_s;
        logic signed [NUM_W-1:0]   num;
        logic signed [COEF_W-1:0]  den;
    } sq_side_t;

    typedef struct packed {
        logic valid;
        cnt_t cnt;
    } pipe_ctl_t;

    function automatic logic signed [ROOT_W-1:0] finish_root(
        input logic signed [QUO_W-1:0] q
    );
        logic signed [ROOT_W-1:0] r;
        r = ROOT_W'(q);
        if (q >= -FLUSH_LIM && q <= FLUSH_LIM)
        begin
            r = '0;
        end
        return r;
    endfunction

endpackage

### sv/qrs_sqrt.sv
module qrs_sqrt (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_vld,
    input  logic [63:0]            rad,
    input  qrs_pkg::sq_side_t      in_side,
    output logic                   out_vld,
    output logic [31:0]            root,
    output qrs_pkg::sq_side_t      out_side
);
    import qrs_pkg::*;

    logic [RAD_W-1:0]    x_reg    [SQ_STEPS];
    logic [SQ_REM_W-1:0] rem_reg  [SQ_STEPS];
    logic [SQ_STEPS-1:0] root_reg [SQ_STEPS];
    sq_side_t            side_reg [SQ_STEPS];
    logic [SQ_STEPS-1:0] vld_reg;

    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_step
        logic [RAD_W-1:0]      x_prev;
        logic [SQ_REM_W-1:0]   rem_prev;
        logic [SQ_STEPS-1:0]   root_prev;
        sq_side_t              side_prev;
        logic                  vld_prev;
        logic [SQ_REM_W+1:0]   trial;
        logic [SQ_REM_W+1:0]   test;
        logic                  ge;
        logic [SQ_REM_W-1:0]   rem_next;

        if (k == 0)
        begin : g_first
            assign x_prev    = rad;
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign side_prev = in_side;
            assign vld_prev  = in_vld;
        end
        else
        begin : g_rest
            assign x_prev    = x_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
            assign side_prev = side_reg[k-1];
            assign vld_prev  = vld_reg[k-1];
        end

        assign trial    = {rem_prev, x_prev[RAD_W-1:RAD_W-2]};
        assign test     = {2'b00, root_prev, 2'b01};
        assign ge       = trial >= test;
        assign rem_next = ge ? SQ_REM_W'(trial - test) : SQ_REM_W'(trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k]    <= {x_prev[RAD_W-3:0], 2'b00};
                rem_reg[k]  <= rem_next;
                root_reg[k] <= {root_prev[SQ_STEPS-2:0], ge};
                side_reg[k] <= side_prev;
            end
        end
    end

    assign out_vld  = vld_reg[SQ_STEPS-1];
    assign root     = root_reg[SQ_STEPS-1];
    assign out_side = side_reg[SQ_STEPS-1];

endmodule

### sv/qrs_div.sv
module qrs_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  qrs_pkg::pipe_ctl_t      in_ctl,
    input  logic signed [41:0]      num1,
    input  logic signed [41:0]      num2,
    input  logic signed [15:0]      den,
    output qrs_pkg::pipe_ctl_t      out_ctl,
    output logic signed [42:0]      quo1,
    output logic signed [42:0]      quo2
);
    import qrs_pkg::*;

    localparam int STEPS = NUM_W;

    logic [NUM_W-1:0]  w1_reg   [STEPS];
    logic [NUM_W-1:0]  w2_reg   [STEPS];
    logic [COEF_W-1:0] r1_reg   [STEPS];
    logic [COEF_W-1:0] r2_reg   [STEPS];
    logic [COEF_W-1:0] d_reg    [STEPS];
    logic              neg1_reg [STEPS];
    logic              neg2_reg [STEPS];
    cnt_t              cnt_reg  [STEPS];
    logic [STEPS-1:0]  vld_reg;

    logic [NUM_W-1:0]  mag1;
    logic [NUM_W-1:0]  mag2;
    logic [COEF_W-1:0] magd;

    assign mag1 = num1[NUM_W-1] ? NUM_W'(-num1) : NUM_W'(num1);
    assign mag2 = num2[NUM_W-1] ? NUM_W'(-num2) : NUM_W'(num2);
    assign magd = den[COEF_W-1] ? COEF_W'(-den) : COEF_W'(den);

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        logic [NUM_W-1:0]  w1_prev;
        logic [NUM_W-1:0]  w2_prev;
        logic [COEF_W-1:0] r1_prev;
        logic [COEF_W-1:0] r2_prev;
        logic [COEF_W-1:0] d_prev;
        logic              n1_prev;
        logic              n2_prev;
        cnt_t              cnt_prev;
        logic              vld_prev;
        logic [COEF_W:0]   t1;
        logic [COEF_W:0]   t2;
        logic              ge1;
        logic              ge2;

        if (k == 0)
        begin : g_first
            assign w1_prev  = mag1;
            assign w2_prev  = mag2;
            assign r1_prev  = '0;
            assign r2_prev  = '0;
            assign d_prev   = magd;
            assign n1_prev  = num1[NUM_W-1] ^ den[COEF_W-1];
            assign n2_prev  = num2[NUM_W-1] ^ den[COEF_W-1];
            assign cnt_prev = in_ctl.cnt;
            assign vld_prev = in_ctl.valid;
        end
        else
        begin : g_rest
            assign w1_prev  = w1_reg[k-1];
            assign w2_prev  = w2_reg[k-1];
            assign r1_prev  = r1_reg[k-1];
            assign r2_prev  = r2_reg[k-1];
            assign d_prev   = d_reg[k-1];
            assign n1_prev  = neg1_reg[k-1];
            assign n2_prev  = neg2_reg[k-1];
            assign cnt_prev = cnt_reg[k-1];
            assign vld_prev = vld_reg[k-1];
        end

        assign t1  = {r1_prev, w1_prev[NUM_W-1]};
        assign t2  = {r2_prev, w2_prev[NUM_W-1]};
        assign ge1 = t1 >= {1'b0, d_prev};
        assign ge2 = t2 >= {1'b0, d_prev};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                w1_reg[k]   <= {w1_prev[NUM_W-2:0], ge1};
                w2_reg[k]   <= {w2_prev[NUM_W-2:0], ge2};
                r1_reg[k]   <= ge1 ? COEF_W'(t1 - {1'b0, d_prev}) : COEF_W'(t1);
                r2_reg[k]   <= ge2 ? COEF_W'(t2 - {1'b0, d_prev}) : COEF_W'(t2);
                d_reg[k]    <= d_prev;
                neg1_reg[k] <= n1_prev;
                neg2_reg[k] <= n2_prev;
                cnt_reg[k]  <= cnt_prev;
            end
        end
    end

    logic signed [QUO_W-1:0] q1_pos;
    logic signed [QUO_W-1:0] q2_pos;

    assign q1_pos        = signed'({1'b0, w1_reg[STEPS-1]});
    assign q2_pos        = signed'({1'b0, w2_reg[STEPS-1]});
    assign quo1          = neg1_reg[STEPS-1] ? -q1_pos : q1_pos;
    assign quo2          = neg2_reg[STEPS-1] ? -q2_pos : q2_pos;
    assign out_ctl.valid = vld_reg[STEPS-1];
    assign out_ctl.cnt   = cnt_reg[STEPS-1];

endmodule

### sv/quadratic_root_solver.sv
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_stall  | coef_a, coef_b, coef_c (signed Q8.8)
// out     | output    | out_valid / out_stall| root_count, first_root, second_root (Q24.24)
//
// One equation per cycle while no result is stalled; stages: input register, multiply,
// discriminant, 32 square-root stages (one root bit each), numerator, 42 divider
// stages (one quotient bit each, both roots in parallel lanes), output register.
// Reset clears only the valid bits and ctl4_reg; the data path holds no state between items.
// A stalled result freezes the whole pipeline; in_stall rises only then.
module quadratic_root_solver (
    input  logic                clk,
    input  logic                rst_n,
    input  logic signed [15:0]  coef_a,
    input  logic signed [15:0]  coef_b,
    input  logic signed [15:0]  coef_c,
    input  logic                in_valid,
    output logic                in_stall,
    output logic [1:0]          root_count,
    output logic signed [47:0]  first_root,
    output logic signed [47:0]  second_root,
    output logic                out_valid,
    input  logic                out_stall
);
    import qrs_pkg::*;

    logic advance;

    logic                       v1_reg;
    logic signed [COEF_W-1:0]   a1_reg;
    logic signed [COEF_W-1:0]   b1_reg;
    logic signed [COEF_W-1:0]   c1_reg;

    logic                       v2_reg;
    logic signed [COEF_W-1:0]   a2_reg;
    logic signed [COEF_W-1:0]   b2_reg;
    logic signed [COEF_W-1:0]   c2_reg;
    logic signed [PROD_W-1:0]   bb_reg;
    logic signed [PROD_W-1:0]   ac_reg;

    logic                       v3_reg;
    logic [RAD_W-1:0]           rad3_reg;
    sq_side_t                   side3_reg;
    logic [RAD_W-1:0]           rad3_next;
    sq_side_t                   side3_next;
    logic signed [DISC_W-1:0]   disc;

    logic                       sq_vld;
    logic [SQ_STEPS-1:0]        sq_root;
    sq_side_t                   sq_side;

    pipe_ctl_t                  ctl4_reg;
    logic signed [NUM_W-1:0]    n1_reg;
    logic signed [NUM_W-1:0]    n2_reg;
    logic signed [COEF_W-1:0]   den4_reg;
    logic signed [NUM_W-1:0]    n1_next;
    logic signed [NUM_W-1:0]    n2_next;
    logic signed [NUM_W-1:0]    s_ext;

    pipe_ctl_t                  div_ctl;
    logic signed [QUO_W-1:0]    quo1;
    logic signed [QUO_W-1:0]    quo2;

    logic                       out_valid_reg;
    cnt_t                       cnt_reg;
    logic signed [ROOT_W-1:0]   r1_reg;
    logic signed [ROOT_W-1:0]   r2_reg;
    logic signed [ROOT_W-1:0]   r1_next;
    logic signed [ROOT_W-1:0]   r2_next;

    assign advance  = !(out_valid_reg && out_stall);
    assign in_stall = !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            ctl4_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            ctl4_reg      <= '{valid: sq_vld, cnt: sq_side.cnt};
            out_valid_reg <= div_ctl.valid;
        end
    end

    always_comb
    begin
        disc       = DISC_W'(bb_reg) - (DISC_W'(ac_reg) <<< 2);
        rad3_next  = '0;
        side3_next = '{cnt: CNT_NONE, use_s: 1'b0, num: '0, den: a2_reg};
        if (a2_reg == '0)
        begin
            side3_next.den = b2_reg;
            side3_next.num = -(NUM_W'(c2_reg) <<< LIN_SH);
            if (b2_reg != '0)
            begin
                side3_next.cnt = CNT_ONE;
            end
            else if (c2_reg == '0)
            begin
                side3_next.cnt = CNT_INF;
            end
        end
        else if (disc == '0)
        begin
            side3_next.cnt = CNT_ONE;
            side3_next.num = -(NUM_W'(b2_reg) <<< DZERO_SH);
        end
        else if (disc > 0)
        begin
            side3_next.cnt   = CNT_TWO;
            side3_next.use_s = 1'b1;
            side3_next.num   = -(NUM_W'(b2_reg) <<< QUAD_SH);
            rad3_next        = RAD_W'(unsigned'(disc)) << RAD_SHIFT;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a1_reg    <= coef_a;
            b1_reg    <= coef_b;
            c1_reg    <= coef_c;
            a2_reg    <= a1_reg;
            b2_reg    <= b1_reg;
            c2_reg    <= c1_reg;
            bb_reg    <= b1_reg * b1_reg;
            ac_reg    <= a1_reg * c1_reg;
            rad3_reg  <= rad3_next;
            side3_reg <= side3_next;
        end
    end

    qrs_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (advance),
        .in_vld   (v3_reg),
        .rad      (rad3_reg),
        .in_side  (side3_reg),
        .out_vld  (sq_vld),
        .root     (sq_root),
        .out_side (sq_side)
    );

    always_comb
    begin
        s_ext   = signed'(NUM_W'(sq_root));
        n1_next = sq_side.num;
        n2_next = '0;
        if (sq_side.use_s)
        begin
            n1_next = (sq_side.num + s_ext) <<< NUM_SH;
            n2_next = (sq_side.num - s_ext) <<< NUM_SH;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            n1_reg   <= n1_next;
            n2_reg   <= n2_next;
            den4_reg <= sq_side.den;
        end
    end

    qrs_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (advance),
        .in_ctl  (ctl4_reg),
        .num1    (n1_reg),
        .num2    (n2_reg),
        .den     (den4_reg),
        .out_ctl (div_ctl),
        .quo1    (quo1),
        .quo2    (quo2)
    );

    always_comb
    begin
        r1_next = '0;
        r2_next = '0;
        if (div_ctl.cnt == CNT_ONE || div_ctl.cnt == CNT_TWO)
        begin
            r1_next = finish_root(quo1);
        end
        if (div_ctl.cnt == CNT_TWO)
        begin
            r2_next = finish_root(quo2);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cnt_reg <= div_ctl.cnt;
            r1_reg  <= r1_next;
            r2_reg  <= r2_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign root_count  = cnt_reg;
    assign first_root  = r1_reg;
    assign second_root = r2_reg;

    a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (root_count == CNT_NONE || root_count == CNT_INF)
        |-> first_root == '0 && second_root == '0)
        else $error("root field set for a count without roots");

    a_second_only_two: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && root_count != CNT_TWO |-> second_root == '0)
        else $error("second root set without two roots");

    a_flushed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> first_root == '0 || first_root > 48'sd167 || first_root < -48'sd167)
        else $error("tiny root not flushed");

endmodule

### verif/qrs_checker.sv
module qrs_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic signed [15:0]  coef_a,
    input  logic signed [15:0]  coef_b,
    input  logic signed [15:0]  coef_c,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [1:0]          root_count,
    input  logic signed [47:0]  first_root,
    input  logic signed [47:0]  second_root,
    input  logic                out_valid,
    input  logic                out_stall,
    output int                  fail_count,
    output int                  pending
);
    import qrs_pkg::*;

    typedef struct {
        cnt_t                     cnt;
        logic signed [47:0]       r1;
        logic signed [47:0]       r2;
    } roots_t;

    roots_t solutions_q[$];

    function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] bit_w;
        r = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > x)
        begin
            bit_w = bit_w >> 2;
        end
        while (bit_w != 0)
        begin
            if (x >= r + bit_w)
            begin
                x = x - (r + bit_w);
                r = (r >> 1) + bit_w;
            end
            else
            begin
                r = r >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return r;
    endfunction

    function automatic logic signed [47:0] clamp_root(input longint q);
        if (q >= -167 && q <= 167)
        begin
            return '0;
        end
        if (q > 64'sh7FFFFFFFFFFF)
        begin
            return 48'sh7FFFFFFFFFFF;
        end
        if (q < -64'sh800000000000)
        begin
            return 48'sh800000000000;
        end
        return q[47:0];
    endfunction

    function automatic roots_t solve_equation(input longint a, input longint b,
                                              input longint c);
        roots_t res;
        longint d;
        longint s;
        longint base;
        res.cnt = CNT_NONE;
        res.r1 = '0;
        res.r2 = '0;
        if (a == 0)
        begin
            if (b != 0)
            begin
                res.r1 = clamp_root((-c * (64'sd1 <<< 24)) / b);
                res.cnt = CNT_ONE;
            end
            else if (c == 0)
            begin
                res.cnt = CNT_INF;
            end
        end
        else
        begin
            d = b * b - 4 * a * c;
            if (d == 0)
            begin
                res.r1 = clamp_root((-b * (64'sd1 <<< 23)) / a);
                res.cnt = CNT_ONE;
            end
            else if (d > 0)
            begin
                s = longint'(floor_sqrt(64'(d) << 30));
                base = -b * (64'sd1 <<< 15);
                res.r1 = clamp_root(((base + s) * 256) / a);
                res.r2 = clamp_root(((base - s) * 256) / a);
                res.cnt = CNT_TWO;
            end
        end
        return res;
    endfunction

    assign pending = solutions_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        roots_t exp_r;
        int errs;
        errs = 0;
        if (!rst_n)
        begin
            fail_count <= 0;
            solutions_q.delete();
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                solutions_q.push_back(solve_equation(coef_a, coef_b, coef_c));
            end
            if (out_valid && !out_stall)
            begin
                if (solutions_q.size() == 0)
                begin
                    $error("unexpected transaction: root_count %0d", root_count);
                    errs++;
                end
                else
                begin
                    exp_r = solutions_q.pop_front();
                    if (root_count !== exp_r.cnt)
                    begin
                        $error("root_count expected %0d actual %0d", exp_r.cnt, root_count);
                        errs++;
                    end
                    if (first_root !== exp_r.r1)
                    begin
                        $error("first_root expected %0d actual %0d", exp_r.r1, first_root);
                        errs++;
                    end
                    if (second_root !== exp_r.r2)
                    begin
                        $error("second_root expected %0d actual %0d", exp_r.r2,
                               second_root);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
        end
    end
endmodule

### verif/tb_top.sv
module tb_top;
    logic               clk;
    logic               rst_n;
    logic signed [15:0] coef_a;
    logic signed [15:0] coef_b;
    logic signed [15:0] coef_c;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         root_count;
    logic signed [47:0] first_root;
    logic signed [47:0] second_root;
    logic               out_valid;
    logic               out_stall;
    int                 fail_count;
    int                 pending;
    int                 idle_cycles;

    quadratic_root_solver u_dut (.*);
    qrs_checker u_chk (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // stall pattern: random phases of free flow, light stalling and heavy stalling
    initial
    begin
        int mode;
        out_stall = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 2);
            repeat ($urandom_range(5, 60))
            begin
                @(negedge clk);
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    default: out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles > 2000)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_equation(input logic [15:0] a, input logic [15:0] b,
                                 input logic [15:0] c);
        coef_a <= a;
        coef_b <= b;
        coef_c <= c;
        in_valid <= 1'b1;
        @(posedge clk iff !in_stall);
        @(negedge clk);
    endtask

    task automatic pause_sender(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles)
        begin
            @(negedge clk);
        end
    endtask

    function automatic logic [15:0] pick_coef();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'(signed'($urandom_range(0, 8)) - 4);
            2: return 16'(signed'($urandom_range(0, 1024)) - 512);
            3: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [15:0] a;
        logic [15:0] k;
        int n;
        rst_n = 1'b0;
        in_valid = 1'b0;
        coef_a = '0;
        coef_b = '0;
        coef_c = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_equation(16'h0000, 16'h0000, 16'h0000);
        send_equation(16'h0000, 16'h0000, 16'h0100);
        send_equation(16'h0000, 16'h0100, 16'h0200);
        send_equation(16'h0000, 16'h8000, 16'h7FFF);
        send_equation(16'h0000, 16'h0001, 16'h8000);
        send_equation(16'h0000, 16'h7FFF, 16'h0001);
        send_equation(16'h0100, 16'hFE00, 16'h0100);
        send_equation(16'h0100, 16'h0000, 16'hFF00);
        send_equation(16'h0100, 16'h0000, 16'h0100);
        send_equation(16'h0001, 16'h7FFF, 16'h0000);
        send_equation(16'h0001, 16'h8000, 16'h8000);
        send_equation(16'h8000, 16'h8000, 16'h7FFF);
        send_equation(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_equation(16'h8000, 16'h7FFF, 16'h8000);
        send_equation(16'h0001, 16'h0000, 16'h8000);
        send_equation(16'h7FFF, 16'h0001, 16'h0000);
        send_equation(16'hFFFF, 16'h0002, 16'hFFFF);
        send_equation(16'h0001, 16'h0000, 16'h0000);

        // hold until the pipeline drains
        in_valid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end

        n = 0;
        while (n < 1100)
        begin
            repeat ($urandom_range(1, 40))
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        // perfect square: b = 2*a*k, c = a*k*k
                        a = 16'(signed'($urandom_range(0, 64)) - 32);
                        k = 16'(signed'($urandom_range(0, 16)) - 8);
                        send_equation(a, 16'(2 * signed'(a) * signed'(k)),
                                      16'(signed'(a) * signed'(k) * signed'(k)));
                    end
                    default: send_equation(pick_coef(), pick_coef(), pick_coef());
                endcase
                n++;
            end
            if ($urandom_range(0, 1))
            begin
                pause_sender($urandom_range(1, 30));
            end
        end

        in_valid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (100) @(negedge clk);
        if (fail_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
